/* rtl/slis_pkg.sv */
// Shared types and constants for the streaming LIS length unit.
// No dependencies; every other file but slis_ram imports this package.
package slis_pkg;

  localparam int VALUE_W  = 32;
  localparam int LENGTH_W = 11;

  // One input item.
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      start_new;
  } in_t;

  // One result item.
  typedef struct packed {
    logic [LENGTH_W-1:0] length;
    logic                full_res;
  } out_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;       // capture key and start flag
    logic rd_last;    // read address selects the last tail
    logic wr_first;   // write key to tail 0, run length becomes 1
    logic wr_extend;  // append key, run length grows by one
    logic set_full;   // flag a dropped extension
    logic srch_init;  // set search bounds to the whole table
    logic srch_step;  // narrow the bounds with the probed tail
    logic wr_slot;    // write key at the search result
    logic finish;     // present the result next cycle
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic empty;       // run is empty or restarts with this item
    logic beats;       // key lies strictly beyond the tail just read
    logic can_extend;  // table has room for another tail
    logic lo_lt_hi;    // search bounds not yet met
  } sts_t;

endpackage

/* rtl/streaming_lis_length_unit.sv */
// Top level of the streaming LIS length unit: controller plus datapath.
// Depends on slis_pkg, slis_ctrl, slis_dp (and slis_ram below it).
//
// Reports, for each signed 32-bit value, the length of the longest strictly
// increasing (cfg_data 0) or strictly decreasing (cfg_data 1) subsequence of
// the run so far, by patience sorting over a tails table in one RAM.
// Present an item with start high while busy is low; it is taken at that edge.
// Exactly one result follows, shown on result for the single cycle in which
// done is high: the receiver cannot stall it, so capture it then. A value
// that would extend a full table is dropped and result.full_res is set.
// operand.start_new clears the run before its value. Write the direction
// only while no item is in flight.
// An item that starts a run is written as tail 0; any other item first reads
// the last tail, then extends the table or hits the full limit if it lies
// beyond it, else binary-searches the tails, with a RAM read and then a
// compare per probe, and writes back at the slot found.
// A new item may be accepted in the same cycle that done is high.
// The tails RAM is not cleared after reset; only entries written in the
// current run are ever read.
module streaming_lis_length_unit
  import slis_pkg::*;
#(
  parameter int MAX_LENGTH = 1024
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  in_t  operand,
  output logic done,
  output out_t result,
  input  logic cfg_we,
  input  logic cfg_data
);

  cmd_t cmd;
  sts_t sts;

  // Sequence load, last-tail check, probe loop and write-back.
  slis_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .sts  (sts),
    .cmd  (cmd),
    .busy (busy)
  );

  // Hold the table, run length and bounds; drive the result registers.
  slis_dp #(
    .MAX_LENGTH(MAX_LENGTH)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .operand (operand),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .cmd     (cmd),
    .sts     (sts),
    .result  (result),
    .done    (done)
  );

endmodule

/* rtl/slis_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module slis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/slis_ctrl.sv */
// Sequencer for the streaming LIS length unit: one item at a time,
// binary search by repeated probe and compare. Depends on slis_pkg.
module slis_ctrl
  import slis_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_LAST  = 5'b00100,
    S_PROBE = 5'b01000,
    S_STEP  = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.empty) begin
          cmd.wr_first = 1'b1;
          cmd.finish   = 1'b1;
          state_next   = S_IDLE;
        end else begin
          cmd.rd_last = 1'b1;
          state_next  = S_LAST;
        end
      end
      S_LAST: begin
        if (sts.beats) begin
          if (sts.can_extend) begin
            cmd.wr_extend = 1'b1;
          end else begin
            cmd.set_full = 1'b1;
          end
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.srch_init = 1'b1;
          state_next    = S_PROBE;
        end
      end
      S_PROBE: begin
        // Read of the midpoint goes out this cycle; it is used only if the bounds have not met.
        if (sts.lo_lt_hi) begin
          state_next = S_STEP;
        end else begin
          cmd.wr_slot = 1'b1;
          cmd.finish  = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_STEP: begin
        cmd.srch_step = 1'b1;
        state_next    = S_PROBE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

/* rtl/slis_dp.sv */
// Datapath for the streaming LIS length unit: key, run length, search
// bounds, direction register and the tails RAM. Depends on slis_pkg, slis_ram.
module slis_dp
  import slis_pkg::*;
#(
  parameter int MAX_LENGTH = 1024
) (
  input  logic clk,
  input  logic rst,
  input  in_t  operand,
  input  logic cfg_we,
  input  logic cfg_data,
  input  cmd_t cmd,
  output sts_t sts,
  output out_t result,
  output logic done
);

  localparam int AW = $clog2(MAX_LENGTH);
  localparam int CW = $clog2(MAX_LENGTH + 1);

  logic [VALUE_W-1:0] key;
  logic               start_new_q;
  logic               direction;
  logic [CW-1:0]      run_len;
  logic [AW-1:0]      lo, hi, mid;
  logic               full;

  logic [CW-1:0]      last_idx;
  logic [AW-1:0]      raddr, waddr;
  logic               we;
  logic [VALUE_W-1:0] rdata;
  logic [CW+LENGTH_W-1:0] len_ext;

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= 1'b0;
      run_len   <= '0;
      done      <= 1'b0;
      full      <= 1'b0;
    end else begin
      if (cfg_we) begin
        direction <= cfg_data;
      end
      if (cmd.wr_first) begin
        run_len <= CW'(1);
      end else if (cmd.wr_extend) begin
        run_len <= run_len + CW'(1);
      end
      done <= cmd.finish;
      if (cmd.finish) begin
        full <= cmd.set_full;
      end
    end
  end

  // Payload registers; key is stored biased so unsigned order is signed order.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key         <= {~operand.value[VALUE_W-1], operand.value[VALUE_W-2:0]};
      start_new_q <= operand.start_new;
    end
    if (cmd.srch_init) begin
      lo <= '0;
      hi <= last_idx[AW-1:0];
    end else if (cmd.srch_step) begin
      if (sts.beats) begin
        lo <= mid + AW'(1);
      end else begin
        hi <= mid;
      end
    end
  end

  assign last_idx = run_len - CW'(1);
  assign mid      = lo + ((hi - lo) >> 1);
  assign raddr    = cmd.rd_last ? last_idx[AW-1:0] : mid;
  assign we       = cmd.wr_first | cmd.wr_extend | cmd.wr_slot;

  always_comb begin
    if (cmd.wr_first) begin
      waddr = '0;
    end else if (cmd.wr_extend) begin
      waddr = run_len[AW-1:0];
    end else begin
      waddr = lo;
    end
  end

  slis_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(MAX_LENGTH)
  ) u_tails (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(key),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign sts.empty      = start_new_q | (run_len == '0);
  assign sts.beats      = direction ? (key < rdata) : (key > rdata);
  assign sts.can_extend = (run_len < CW'(MAX_LENGTH));
  assign sts.lo_lt_hi   = (lo < hi);

  assign len_ext         = {{LENGTH_W{1'b0}}, run_len};
  assign result.length   = len_ext[LENGTH_W-1:0];
  assign result.full_res = full;

endmodule
